// File: rtl/core/bpa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator.
// ---------------------------------------------------------------------------
package bpa_pkg;

	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;
	localparam int STATUS_W  = 3;

	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOMEM        = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISALIGNED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} bpa_zero_t;

endpackage
`default_nettype wire

// File: rtl/core/bitmap_page_allocator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page frame allocator over a used-page bitmap with a summary
// level of per-word full bits, both held in single-port-style memories.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall) carries one word: action and address.
//   rsp channel (rsp_valid/rsp_stall) returns one word per request:
//   page_address, status and free_count.
//   cfg channel (cfg_valid/cfg_ready) writes total_pages; cfg_ready is
//   always high. Write it only while no request is in flight.
// Flow (one request at a time, req_stall high while busy):
//   free:     a rejected address goes straight to S_DONE; otherwise S_FRD,
//             S_FCHK, S_SCHK when the word was full, then S_DONE.
//   allocate: S_SCAN reads summary words (at most ceil(MAX_PAGE_COUNT /
//             4096)), one summary word per cycle, then S_WRD, S_WCHK and
//             S_DONE; S_SCAN goes to S_DONE when every summary word is full.
// Reset: both memories are treated as clear at once through a word fill
//   count; no clearing pass is run. total_pages resets to 65536.
// Stall: a finished result sits in the output register until taken; the
//   next request is accepted meanwhile and waits only to hand off its result.
// ---------------------------------------------------------------------------
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int MAX_PAGE_COUNT = 65536,
	parameter int PAGE_BYTES     = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,

	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [16:0]   total_pages,

	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire logic          action,
	input  wire logic [31:0]   address,

	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output logic [27:0]        page_address,
	output logic [STATUS_W-1:0] status,
	output logic [16:0]        free_count
);

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int WORD_COUNT = (MAX_PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int SUM_COUNT  = (WORD_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int SA_W       = (SUM_COUNT > 1) ? $clog2(SUM_COUNT) : 1;
	localparam int HW_W       = $clog2(WORD_COUNT + 1);
	localparam int WX_W       = SA_W + BIT_W + 1;
	localparam int FIDX_W     = 32 - PAGE_SHIFT;
	localparam int AIDX_W     = SA_W + 2 * BIT_W;
	localparam int CMP0_W     = (FIDX_W > AIDX_W) ? FIDX_W : AIDX_W;
	localparam int CMP_W      = ((CMP0_W > 17) ? CMP0_W : 17) + 1;
	localparam int MAXC_W0    = $clog2(MAX_PAGE_COUNT + 1);
	localparam int MAXC_W     = (MAXC_W0 > 17) ? MAXC_W0 : 17;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_WRD  = 3'd2;
	localparam logic [2:0] S_WCHK = 3'd3;
	localparam logic [2:0] S_FRD  = 3'd4;
	localparam logic [2:0] S_FCHK = 3'd5;
	localparam logic [2:0] S_SCHK = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]            state_q;
	logic [16:0]           total_pages_q;
	logic [16:0]           used_count_q;
	logic [HW_W-1:0]       hwm_q;
	logic [SA_W:0]         scan_q;
	logic [SA_W:0]         chk_s_q;
	logic                  chk_v_q;
	logic [SA_W+BIT_W-1:0] w_q;
	logic [BIT_W-1:0]      b_q;
	logic [WORD_BITS-1:0]  sum_word_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [27:0]           res_paddr_q;
	logic                  rsp_valid_q;
	logic [27:0]           page_address_q;
	logic [STATUS_W-1:0]   status_q;
	logic [16:0]           free_count_q;

	logic [WORD_BITS-1:0]  bm_mem [WORD_COUNT];
	logic [WORD_BITS-1:0]  sum_mem [SUM_COUNT];
	logic [WORD_BITS-1:0]  bm_rdata;
	logic [WORD_BITS-1:0]  sum_rdata;
	logic                  bm_we;
	logic [WORD_BITS-1:0]  bm_wdata;
	logic                  sum_we;
	logic [WORD_BITS-1:0]  sum_wdata;
	logic [SA_W-1:0]       sum_raddr;
	logic [SA_W-1:0]       w_sum;

	logic [MAXC_W-1:0]     lim_x;
	logic [16:0]           limit;
	logic [WX_W-1:0]       hwm_x;
	logic [WX_W-1:0]       w_x;
	logic [WX_W-1:0]       w_next;
	logic                  w_live;
	logic [SA_W:0]         mask_s;
	logic [WORD_BITS-1:0]  sum_masked;
	logic [WORD_BITS-1:0]  bm_word;
	logic [WORD_BITS-1:0]  w_bit;
	logic [WORD_BITS-1:0]  b_bit;
	bpa_zero_t             sum_zero;
	bpa_zero_t             bm_zero;
	logic [AIDX_W-1:0]     aidx;
	logic                  alloc_ok;
	logic [FIDX_W-1:0]     fidx;
	logic                  misaligned;
	logic                  beyond;

	function automatic logic [WORD_BITS-1:0] sum_mask(input logic [SA_W:0] s,
			input logic [WX_W-1:0] hw);
		logic [WORD_BITS-1:0] m;
		for (int i = 0; i < WORD_BITS; i++) begin
			m[i] = {s, BIT_W'(i)} < hw;
		end
		return m;
	endfunction

	// effective page count
	always_comb begin
		lim_x = MAXC_W'(total_pages_q);
		if (lim_x > MAXC_W'(MAX_PAGE_COUNT)) begin
			lim_x = MAXC_W'(MAX_PAGE_COUNT);
		end
		limit = lim_x[16:0];
	end

	assign hwm_x  = WX_W'(hwm_q);
	assign w_x    = WX_W'(w_q);
	assign w_next = w_x + WX_W'(1);
	assign w_live = w_x < hwm_x;
	assign w_sum  = w_q[SA_W+BIT_W-1:BIT_W];

	assign mask_s     = (state_q == S_SCAN) ? chk_s_q : {1'b0, w_sum};
	assign sum_masked = sum_rdata & sum_mask(mask_s, hwm_x);
	assign bm_word    = w_live ? bm_rdata : '0;
	assign w_bit      = WORD_BITS'(1) << w_q[BIT_W-1:0];
	assign b_bit      = WORD_BITS'(1) << b_q;

	bpa_lowzero u_sum_zero (
		.word (sum_masked),
		.zero (sum_zero)
	);

	bpa_lowzero u_bm_zero (
		.word (bm_word),
		.zero (bm_zero)
	);

	assign aidx     = {w_q, bm_zero.pos};
	assign alloc_ok = bm_zero.found && (w_x < WX_W'(WORD_COUNT))
		&& (CMP_W'(aidx) < CMP_W'(limit));

	assign fidx       = address[31:PAGE_SHIFT];
	assign misaligned = address[PAGE_SHIFT-1:0] != '0;
	assign beyond     = CMP_W'(fidx) >= CMP_W'(limit);

	// memory port control
	always_comb begin
		sum_raddr = (state_q == S_SCAN) ? scan_q[SA_W-1:0] : w_sum;
		bm_we     = 1'b0;
		bm_wdata  = bm_word & ~b_bit;
		sum_we    = 1'b0;
		sum_wdata = sum_masked & ~w_bit;
		case (state_q)
			S_WCHK: begin
				bm_wdata  = bm_word | (WORD_BITS'(1) << bm_zero.pos);
				bm_we     = alloc_ok;
				// summary word rewritten on every successful allocation so live words hold valid bits
				sum_wdata = (bm_wdata == '1) ? (sum_word_q | w_bit) : sum_word_q;
				sum_we    = alloc_ok;
			end
			S_FCHK: begin
				bm_we = bm_word[b_q];
			end
			S_SCHK: begin
				sum_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[w_q[WA_W-1:0]] <= bm_wdata;
		end
		bm_rdata <= bm_mem[w_q[WA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[w_sum] <= sum_wdata;
		end
		sum_rdata <= sum_mem[sum_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			total_pages_q <= 17'h10000;
			used_count_q  <= '0;
			hwm_q         <= '0;
			chk_v_q       <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				total_pages_q <= total_pages;
			end
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					scan_q  <= '0;
					chk_v_q <= 1'b0;
					res_paddr_q <= '0;
					if (req_valid) begin
						w_q <= (SA_W+BIT_W)'(fidx >> BIT_W);
						b_q <= fidx[BIT_W-1:0];
						if (!action) begin
							state_q <= S_SCAN;
						end else if (misaligned) begin
							res_status_q <= ST_MISALIGNED;
							state_q      <= S_DONE;
						end else if (beyond) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_FRD;
						end
					end
				end
				S_SCAN: begin
					scan_q  <= scan_q + 1'b1;
					chk_s_q <= scan_q;
					chk_v_q <= scan_q < (SA_W+1)'(SUM_COUNT);
					if (chk_v_q) begin
						if (sum_zero.found) begin
							w_q        <= {chk_s_q[SA_W-1:0], sum_zero.pos};
							sum_word_q <= sum_masked;
							state_q    <= S_WRD;
						end else if (chk_s_q == (SA_W+1)'(SUM_COUNT - 1)) begin
							res_status_q <= ST_NOMEM;
							state_q      <= S_DONE;
						end
					end
				end
				S_WRD: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (alloc_ok) begin
						used_count_q <= used_count_q + 1'b1;
						if (w_next > hwm_x) begin
							hwm_q <= w_next[HW_W-1:0];
						end
						res_paddr_q  <= 28'({28'd0, aidx, {PAGE_SHIFT{1'b0}}});
						res_status_q <= ST_OK;
					end else begin
						res_status_q <= ST_NOMEM;
					end
					state_q <= S_DONE;
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (bm_word[b_q]) begin
						if (used_count_q != '0) begin
							used_count_q <= used_count_q - 1'b1;
						end
						res_status_q <= ST_OK;
						state_q      <= (bm_word == '1) ? S_SCHK : S_DONE;
					end else begin
						res_status_q <= ST_ALREADY_FREE;
						state_q      <= S_DONE;
					end
				end
				S_SCHK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			page_address_q <= res_paddr_q;
			status_q       <= res_status_q;
			free_count_q   <= (limit > used_count_q) ? (limit - used_count_q) : '0;
		end
	end

	assign cfg_ready    = 1'b1;
	assign req_stall    = state_q != S_IDLE;
	assign rsp_valid    = rsp_valid_q;
	assign page_address = page_address_q;
	assign status       = status_q;
	assign free_count   = free_count_q;

endmodule
`default_nettype wire

// File: rtl/core/bpa_lowzero.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bpa_lowzero
// Priority encoder: position of the lowest clear bit of a 64-bit word.
// ---------------------------------------------------------------------------
module bpa_lowzero
	import bpa_pkg::*;
(
	input  wire logic [WORD_BITS-1:0] word,
	output bpa_zero_t                 zero
);

	always_comb begin
		zero.found = 1'b0;
		zero.pos   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				zero.found = 1'b1;
				zero.pos   = BIT_W'(i);
			end
		end
	end

endmodule
`default_nettype wire

// File: verif/tb_bitmap_page_allocator.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_bitmap_page_allocator
// Self-checking bench for the first-fit page allocator. A scoreboard keeps
// its own page bitmap and used count, predicts the word returned for every
// accepted request and compares it field by field. A directed opener covers
// double free, misaligned and out-of-range frees, an empty or lowered page
// count and an oversized count. Random fill/drain runs then follow under
// several page counts, with random request gaps and response stalls.
// ---------------------------------------------------------------------------
module tb_bitmap_page_allocator;
	import bpa_pkg::*;

	localparam int unsigned PAGE_CAP    = 65536;
	localparam int unsigned PAGE_BYTES  = 4096;
	localparam int unsigned MAP_WORDS   = PAGE_CAP / 64;
	localparam int unsigned TOP_PAGE    = 1048575;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned N_PHASES    = 12;
	localparam int unsigned PHASE_ITEMS = 115;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int PHASE_PAGES [N_PHASES] =
		'{8, 64, 65, 3, 200, 1, 0, 131071, 65536, 100, 70000, 17};

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef struct {
		logic [27:0]         page_addr;
		logic [STATUS_W-1:0] status;
		logic [16:0]         free_count;
	} page_result_t;

	class page_scoreboard;
		logic [63:0]  used_map [MAP_WORDS];
		int unsigned  used_pages;
		int unsigned  high_water;
		logic [16:0]  total_reg;
		page_result_t expected_q [$];
		int unsigned  mismatches;
		int unsigned  requests;
		int unsigned  results;
		int unsigned  status_hits [5];

		function new();
			foreach (used_map[i]) used_map[i] = '0;
			foreach (status_hits[i]) status_hits[i] = 0;
			used_pages = 0;
			high_water = 0;
			total_reg  = 17'd65536;
			mismatches = 0;
			requests   = 0;
			results    = 0;
		endfunction

		function int unsigned page_limit();
			return (total_reg > PAGE_CAP) ? PAGE_CAP : int'(total_reg);
		endfunction

		function logic [16:0] free_pages();
			int unsigned lim;
			lim = page_limit();
			return (lim > used_pages) ? 17'(lim - used_pages) : 17'd0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void set_total(logic [16:0] n);
			total_reg = n;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void note_request(logic act, logic [31:0] adr);
			page_result_t r;
			int unsigned  lim;
			int unsigned  idx;
			bit           found;
			lim         = page_limit();
			r.page_addr = '0;
			found       = 1'b0;
			idx         = 0;
			if (act == ACT_ALLOC) begin
				for (int unsigned w = 0; w < MAP_WORDS && !found && w * 64 < lim; w++) begin
					if (used_map[w] != '1) begin
						for (int unsigned b = 0; b < 64 && !found && w * 64 + b < lim; b++) begin
							if (!used_map[w][b]) begin
								found = 1'b1;
								idx   = w * 64 + b;
							end
						end
					end
				end
				if (found) begin
					used_map[idx / 64][idx % 64] = 1'b1;
					used_pages++;
					if (idx > high_water)
						high_water = idx;
					r.page_addr = 28'(idx * PAGE_BYTES);
					r.status    = ST_OK;
				end else begin
					r.status = ST_NOMEM;
				end
			end else if (adr % PAGE_BYTES != 0) begin
				r.status = ST_MISALIGNED;
			end else begin
				idx = adr / PAGE_BYTES;
				if (idx >= lim) begin
					r.status = ST_RANGE;
				end else if (used_map[idx / 64][idx % 64]) begin
					used_map[idx / 64][idx % 64] = 1'b0;
					if (used_pages > 0)
						used_pages--;
					r.status = ST_OK;
				end else begin
					r.status = ST_ALREADY_FREE;
				end
			end
			r.free_count = free_pages();
			status_hits[r.status]++;
			requests++;
			expected_q.push_back(r);
		endfunction

		function void check_response(logic [27:0] pa, logic [STATUS_W-1:0] st,
				logic [16:0] fc);
			page_result_t e;
			results++;
			if (expected_q.size() == 0) begin
				flag($sformatf("unexpected word: page_address %h status %0d free_count %0d",
					pa, st, fc));
				return;
			end
			e = expected_q.pop_front();
			if (pa !== e.page_addr || st !== e.status || fc !== e.free_count)
				flag($sformatf({"word %0d mismatch (exp/act): page_address %h/%h ",
					"status %0d/%0d free_count %0d/%0d"}, results,
					e.page_addr, pa, e.status, st, e.free_count, fc));
		endfunction
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_valid    = 1'b0;
	logic                cfg_ready;
	logic [16:0]         cfg_pages    = '0;
	logic                req_valid    = 1'b0;
	logic                req_stall;
	logic                action       = 1'b0;
	logic [31:0]         address      = '0;
	logic                rsp_valid;
	logic                rsp_stall    = 1'b0;
	logic [27:0]         page_address;
	logic [STATUS_W-1:0] status;
	logic [16:0]         free_count;

	page_scoreboard sb;
	int unsigned    cycles      = 0;
	int unsigned    settings    = 0;
	int unsigned    stall_left  = 0;
	int unsigned    holds_done  = 0;

	bitmap_page_allocator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.total_pages  (cfg_pages),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.address      (address),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.page_address (page_address),
		.status       (status),
		.free_count   (free_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// response side: check, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(page_address, status, free_count);
		if (holds_done < 2 && sb.results >= (holds_done == 0 ? 250 : 900)) begin
			stall_left = LONG_HOLD;
			holds_done++;
		end
		if (stall_left == 0)
			stall_left = pick_gap(((cycles / 1500) % 4) == 1);
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_req(input logic act, input logic [31:0] adr, input bit calm);
		int unsigned gap;
		gap = pick_gap(calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		action    <= act;
		address   <= adr;
		do @(posedge clk); while (req_stall);
		sb.note_request(act, adr);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_total(input logic [16:0] n);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_pages <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_total(n);
		settings++;
	endtask

	initial begin
		logic        act;
		logic [31:0] adr;
		bit          fill;
		int unsigned run_left;
		int unsigned r;
		int unsigned lim;
		int unsigned pg;

		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opener at the reset page count
		send_req(ACT_FREE, 32'h0000_0000, 1'b1);
		send_req(ACT_ALLOC, 32'h0000_0000, 1'b1);
		send_req(ACT_ALLOC, 32'hFFFF_FFFF, 1'b1);
		send_req(ACT_FREE, 32'h0000_1000, 1'b1);
		send_req(ACT_FREE, 32'h0000_1000, 1'b1);
		send_req(ACT_ALLOC, 32'h0000_0000, 1'b1);
		send_req(ACT_ALLOC, 32'h0000_0000, 1'b1);
		send_req(ACT_FREE, 32'h0000_0001, 1'b1);
		send_req(ACT_FREE, 32'hFFFF_FFFF, 1'b1);    // misaligned beats range
		send_req(ACT_FREE, 32'hFFFF_F000, 1'b1);
		send_req(ACT_FREE, 32'h1000_0000, 1'b1);    // first page past the end
		send_req(ACT_FREE, 32'h0FFF_F000, 1'b1);    // top page, never used
		send_req(ACT_FREE, 32'h0000_0800, 1'b1);
		write_total(17'd0);
		send_req(ACT_ALLOC, 32'h0000_0000, 1'b1);
		send_req(ACT_FREE, 32'h0000_0000, 1'b1);
		write_total(17'd1);                        // below pages in use
		send_req(ACT_ALLOC, 32'h0000_0000, 1'b1);
		send_req(ACT_FREE, 32'h0000_1000, 1'b1);
		send_req(ACT_FREE, 32'h0000_0000, 1'b1);
		send_req(ACT_ALLOC, 32'h0000_0000, 1'b1);
		write_total(17'h1FFFF);                    // oversized, caps
		send_req(ACT_FREE, 32'h0FFF_F000, 1'b1);
		send_req(ACT_ALLOC, 32'h0000_0000, 1'b1);

		for (int p = 0; p < N_PHASES; p++) begin
			write_total(17'(PHASE_PAGES[p]));
			fill     = 1'b1;
			run_left = $urandom_range(10, 60);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					drain_results();
				if (run_left == 0) begin
					fill     = !fill;
					run_left = $urandom_range(10, 60);
				end
				run_left--;
				lim = sb.page_limit();
				r   = $urandom_range(0, 99);
				if (r < (fill ? 70 : 25)) begin
					act = ACT_ALLOC;
					adr = $urandom;
				end else begin
					act = ACT_FREE;
					r   = $urandom_range(0, 99);
					if (r < 70) begin
						adr = 32'($urandom_range(0, sb.high_water + 2) * PAGE_BYTES);
					end else if (r < 80) begin
						adr = {20'($urandom), 12'($urandom_range(1, 4095))};
					end else if (r < 92) begin
						pg  = (r % 2 == 0) ? lim : $urandom_range(lim, TOP_PAGE);
						adr = 32'(pg * PAGE_BYTES);
					end else begin
						adr = $urandom;
					end
				end
				send_req(act, adr, (i % 100) < 20);
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		$display("Covered %0d requests over %0d page-count settings, %0d words checked.",
			sb.requests, settings, sb.results);
		$display("Outcomes: ok %0d, out of memory %0d, misaligned %0d, range %0d, already free %0d",
			sb.status_hits[ST_OK], sb.status_hits[ST_NOMEM], sb.status_hits[ST_MISALIGNED],
			sb.status_hits[ST_RANGE], sb.status_hits[ST_ALREADY_FREE]);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d words outstanding", sb.mismatches, sb.pending());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: bitmap_page_allocator.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_lowzero.sv
rtl/core/bitmap_page_allocator.sv
verif/tb_bitmap_page_allocator.sv
